>>> sv/kms_pkg.sv
package kms_pkg;

  localparam int ROWS_DEF        = 8;
  localparam int SELECT_BITS_DEF = 3;
  localparam int SAMPLE_W        = 8;
  localparam int INDEX_W         = 3;

  typedef struct packed {
    logic               event_valid;
    logic [INDEX_W-1:0] event_row;
    logic [INDEX_W-1:0] event_col;
    logic               key_down;
    logic [INDEX_W-1:0] next_select;
    logic               any_pressed;
    logic               last;
  } result_t;

  typedef struct packed {
    logic load;
    logic step;
    logic finish;
  } kms_cmd_t;

  typedef struct packed {
    logic pend_valid;
    logic col_last;
    logic change;
    logic out_free;
    logic walk_end;
  } kms_stat_t;

endpackage

>>> sv/kms_in_if.sv
interface kms_in_if
  import kms_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] row_bits;

  modport source (output valid, output row_bits, input ready);
  modport sink (input valid, input row_bits, output ready);
endinterface

>>> sv/kms_out_if.sv
interface kms_out_if
  import kms_pkg::*;
();
  logic               valid;
  logic               ready;
  logic               event_valid;
  logic [INDEX_W-1:0] event_row;
  logic [INDEX_W-1:0] event_col;
  logic               key_down;
  logic [INDEX_W-1:0] next_select;
  logic               any_pressed;
  logic               last;

  modport source (
    output valid, output event_valid, output event_row, output event_col,
    output key_down, output next_select, output any_pressed, output last,
    input ready
  );
  modport sink (
    input valid, input event_valid, input event_row, input event_col,
    input key_down, input next_select, input any_pressed, input last,
    output ready
  );
endinterface

>>> sv/demux_key_matrix_scanner.sv
// Key matrix scanner for a matrix whose columns are picked through a binary
// demultiplexer. Each sample transfer carries the row pins read for the column
// now selected; the result names the select value to drive next. A sample for
// a column other than the last gives one result and the input is ready again
// once the result has moved into the output register; a result still held
// there by the receiver delays this. The sample for the last column starts a
// walk over all ROWS x 2^SELECT_BITS keys, one key per cycle in row-major order
// while no change meets a pending event that the output register cannot take,
// followed by a closing step and the release of the final result, after which
// the input is ready again; a stall on the result side delays this. The walk
// emits one event per changed key; the final result of a scan carries last and
// any_pressed. Reported key state is all released after reset.
module demux_key_matrix_scanner
  import kms_pkg::*;
#(
  parameter int ROWS        = ROWS_DEF,
  parameter int SELECT_BITS = SELECT_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  kms_in_if.sink    samples,
  kms_out_if.source results
);

  kms_cmd_t  cmd;
  kms_stat_t stat;
  result_t   res;

  kms_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (samples.valid),
    .in_ready (samples.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  kms_datapath #(
    .ROWS        (ROWS),
    .SELECT_BITS (SELECT_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .row_bits  (samples.row_bits),
    .out_ready (results.ready),
    .out_valid (results.valid),
    .out_data  (res)
  );

  assign results.event_valid = res.event_valid;
  assign results.event_row   = res.event_row;
  assign results.event_col   = res.event_col;
  assign results.key_down    = res.key_down;
  assign results.next_select = res.next_select;
  assign results.any_pressed = res.any_pressed;
  assign results.last        = res.last;

endmodule

>>> sv/kms_ctrl.sv
module kms_ctrl
  import kms_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  kms_stat_t stat,
  output kms_cmd_t  cmd
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_WALK   = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       step_ok;

  assign in_ready = (state == ST_IDLE) && !stat.pend_valid;

  // A change found while an event is still pending must push that event out first.
  assign step_ok = !stat.change || !stat.pend_valid || stat.out_free;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.load = 1'b1;
          if (stat.col_last) begin
            state_next = ST_WALK;
          end
        end
      end
      ST_WALK: begin
        cmd.step = step_ok;
        if (step_ok && stat.walk_end) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        cmd.finish = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

>>> sv/kms_datapath.sv
module kms_datapath
  import kms_pkg::*;
#(
  parameter int ROWS        = ROWS_DEF,
  parameter int SELECT_BITS = SELECT_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  kms_cmd_t            cmd,
  output kms_stat_t           stat,
  input  logic [SAMPLE_W-1:0] row_bits,
  input  logic                out_ready,
  output logic                out_valid,
  output result_t             out_data
);

  localparam int COLS = 1 << SELECT_BITS;
  localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam logic [SELECT_BITS-1:0] COL_LAST = SELECT_BITS'(COLS - 1);
  localparam logic [RW-1:0]          ROW_LAST = RW'(ROWS - 1);

  logic [ROWS-1:0]        scan_buf [COLS];
  logic [ROWS-1:0]        reported [COLS];
  logic [SELECT_BITS-1:0] col_cnt;
  logic [SELECT_BITS-1:0] walk_c;
  logic [RW-1:0]          walk_r;
  logic                   any;
  logic                   pend_valid;
  logic                   pend_rel;
  result_t                pend;
  result_t                pend_next;

  logic [ROWS-1:0] sample;
  logic [ROWS-1:0] scan_row;
  logic [ROWS-1:0] rep_row;
  logic            now_bit;
  logic            was_bit;
  logic            out_free;
  logic            push;
  logic            rel_move;

  assign sample   = ROWS'(row_bits);
  assign scan_row = scan_buf[walk_c];
  assign rep_row  = reported[walk_c];
  assign now_bit  = scan_row[walk_r];
  assign was_bit  = rep_row[walk_r];

  assign out_free = !out_valid || out_ready;
  assign push     = cmd.step && (now_bit != was_bit) && pend_valid;
  assign rel_move = pend_valid && pend_rel && out_free;

  assign stat.pend_valid = pend_valid;
  assign stat.col_last   = (col_cnt == COL_LAST);
  assign stat.change     = (now_bit != was_bit);
  assign stat.out_free   = out_free;
  assign stat.walk_end   = (walk_r == ROW_LAST) && (walk_c == COL_LAST);

  // Scan buffer needs no reset: every column is written before the walk reads it.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      scan_buf[col_cnt] <= sample;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < COLS; i++) begin
        reported[i] <= '0;
      end
    end else if (cmd.step && (now_bit != was_bit)) begin
      reported[walk_c][walk_r] <= now_bit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_cnt <= '0;
      walk_c  <= '0;
      walk_r  <= '0;
    end else if (cmd.load) begin
      walk_c  <= '0;
      walk_r  <= '0;
      col_cnt <= (col_cnt == COL_LAST) ? '0 : col_cnt + 1'b1;
    end else if (cmd.step) begin
      if (walk_c == COL_LAST) begin
        walk_c <= '0;
        walk_r <= walk_r + 1'b1;
      end else begin
        walk_c <= walk_c + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      any <= 1'b0;
    end else if (cmd.step) begin
      any <= any | now_bit;
    end
  end

  // The pending stage holds the newest event until it is known whether
  // another change follows, which decides its last flag.
  always_comb begin
    pend_next = pend;
    if (cmd.load && (col_cnt != COL_LAST)) begin
      pend_next             = '0;
      pend_next.next_select = INDEX_W'(col_cnt + 1'b1);
      pend_next.last        = 1'b1;
    end else if (cmd.step && (now_bit != was_bit)) begin
      pend_next             = '0;
      pend_next.event_valid = 1'b1;
      pend_next.event_row   = INDEX_W'(walk_r);
      pend_next.event_col   = INDEX_W'(walk_c);
      pend_next.key_down    = now_bit;
    end else if (cmd.finish) begin
      if (!pend_valid) begin
        pend_next = '0;
      end
      pend_next.any_pressed = any;
      pend_next.last        = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    pend <= pend_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      pend_rel   <= 1'b0;
    end else begin
      if (rel_move) begin
        pend_valid <= 1'b0;
      end
      if (cmd.load && (col_cnt != COL_LAST)) begin
        pend_valid <= 1'b1;
        pend_rel   <= 1'b1;
      end else if (cmd.step && (now_bit != was_bit)) begin
        pend_valid <= 1'b1;
        pend_rel   <= 1'b0;
      end else if (cmd.finish) begin
        pend_valid <= 1'b1;
        pend_rel   <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push || rel_move) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push || rel_move) begin
      out_data <= pend;
    end
  end

endmodule

>>> sv/kms_checker.sv
module kms_checker
  import kms_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic               event_valid,
  input logic [INDEX_W-1:0] event_row,
  input logic [INDEX_W-1:0] event_col,
  input logic               key_down,
  input logic [INDEX_W-1:0] next_select,
  input logic               any_pressed,
  input logic               last
);

  // A held result keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(event_valid) &&
      $stable(event_row) && $stable(event_col) && $stable(key_down) &&
      $stable(next_select) && $stable(any_pressed) && $stable(last))
    else $error("result changed while stalled");

  // An accepted sample closes the input for at least the next cycle.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("sample accepted in back-to-back cycles");

  a_quiet_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && !event_valid |-> event_row == '0 && event_col == '0 && !key_down)
    else $error("non-event result carries key fields");

  a_select_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && next_select != '0 |-> last && !event_valid && !any_pressed)
    else $error("column result malformed");

  a_any_on_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && any_pressed |-> last)
    else $error("any_pressed on a result that is not last");

endmodule

bind demux_key_matrix_scanner kms_checker u_kms_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (samples.valid),
  .in_ready    (samples.ready),
  .out_valid   (results.valid),
  .out_ready   (results.ready),
  .event_valid (results.event_valid),
  .event_row   (results.event_row),
  .event_col   (results.event_col),
  .key_down    (results.key_down),
  .next_select (results.next_select),
  .any_pressed (results.any_pressed),
  .last        (results.last)
);

>>> dv/demux_key_matrix_scanner_tb.sv
`timescale 1ns / 1ps

module demux_key_matrix_scanner_tb;
  import kms_pkg::*;

  localparam int COLS         = 1 << SELECT_BITS_DEF;
  localparam int LAST_COL     = COLS - 1;
  localparam int DRAIN_CYCLES = 2 * (ROWS_DEF * COLS + 2);
  localparam int CYCLE_LIMIT  = 1_500_000;
  localparam int PRINT_CAP    = 30;
  localparam logic [SAMPLE_W-1:0] ROW_MASK = SAMPLE_W'((1 << ROWS_DEF) - 1);

  typedef enum logic [2:0] {
    MODE_FLIP,
    MODE_RANDOM,
    MODE_CLEAR,
    MODE_FULL,
    MODE_HOLD
  } scan_mode_e;

  // One directed sample. Where typed is set, the quiet result that it causes is
  // written out here instead of being taken from the predictor.
  typedef struct packed {
    logic [SAMPLE_W-1:0] bits;
    logic                typed;
    logic [INDEX_W-1:0]  sel;
    logic                any;
  } probe_t;

  probe_t probe_table [24] = '{
    // Scan of an empty matrix right after reset: no change at all.
    '{8'h00, 1'b1, 3'd1, 1'b0},
    '{8'h00, 1'b1, 3'd2, 1'b0},
    '{8'h00, 1'b1, 3'd3, 1'b0},
    '{8'h00, 1'b1, 3'd4, 1'b0},
    '{8'h00, 1'b1, 3'd5, 1'b0},
    '{8'h00, 1'b1, 3'd6, 1'b0},
    '{8'h00, 1'b1, 3'd7, 1'b0},
    '{8'h00, 1'b1, 3'd0, 1'b0},
    // Every key goes down, so the last event carries the end of the scan.
    '{8'hFF, 1'b1, 3'd1, 1'b0},
    '{8'hFF, 1'b1, 3'd2, 1'b0},
    '{8'hFF, 1'b1, 3'd3, 1'b0},
    '{8'hFF, 1'b1, 3'd4, 1'b0},
    '{8'hFF, 1'b1, 3'd5, 1'b0},
    '{8'hFF, 1'b1, 3'd6, 1'b0},
    '{8'hFF, 1'b1, 3'd7, 1'b0},
    '{8'hFF, 1'b0, 3'd0, 1'b0},
    // A single key is released while the rest stay held.
    '{8'hFF, 1'b1, 3'd1, 1'b0},
    '{8'hFF, 1'b1, 3'd2, 1'b0},
    '{8'hFF, 1'b1, 3'd3, 1'b0},
    '{8'h7F, 1'b1, 3'd4, 1'b0},
    '{8'hFF, 1'b1, 3'd5, 1'b0},
    '{8'hFF, 1'b1, 3'd6, 1'b0},
    '{8'hFF, 1'b1, 3'd7, 1'b0},
    '{8'hFF, 1'b0, 3'd0, 1'b0}
  };

  logic clk;
  logic rst;

  kms_in_if  samples ();
  kms_out_if results ();

  demux_key_matrix_scanner dut (
    .clk     (clk),
    .rst     (rst),
    .samples (samples),
    .results (results)
  );

  logic [INDEX_W-1:0]  pred_col;
  logic [SAMPLE_W-1:0] scan_rows  [COLS];
  logic [SAMPLE_W-1:0] known_keys [COLS];
  result_t             expected_results [$];
  result_t             want_r;
  scan_mode_e          scan_mode;

  int idle_pct;
  int stall_pct;
  int hold_len;
  int hold_left;
  int error_count;
  int cycle_count;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic flag_mismatch(input string what, input int got, input int want);
    error_count++;
    if (error_count <= PRINT_CAP) begin
      $display("%0t: %s: got %0d, expected %0d", $time, what, got, want);
    end
  endtask

  // Works out the results of one accepted sample and queues them in order.
  function automatic void scan_predict(input logic [SAMPLE_W-1:0] bits,
                                       input logic typed, input result_t fixed);
    result_t found [$];
    result_t r;
    logic    now_bit;
    logic    any;

    scan_rows[pred_col] = bits & ROW_MASK;
    if (pred_col != LAST_COL) begin
      r = '0;
      r.next_select = pred_col + 1'b1;
      r.last = 1'b1;
      found.push_back(r);
      pred_col = pred_col + 1'b1;
    end else begin
      pred_col = '0;
      any = 1'b0;
      for (int rw = 0; rw < ROWS_DEF; rw++) begin
        for (int c = 0; c < COLS; c++) begin
          now_bit = scan_rows[c][rw];
          any = any | now_bit;
          if (now_bit != known_keys[c][rw]) begin
            known_keys[c][rw] = now_bit;
            r = '0;
            r.event_valid = 1'b1;
            r.event_row = INDEX_W'(rw);
            r.event_col = INDEX_W'(c);
            r.key_down = now_bit;
            found.push_back(r);
          end
        end
      end
      if (found.size() == 0) begin
        r = '0;
      end else begin
        r = found.pop_back();
      end
      r.any_pressed = any;
      r.last = 1'b1;
      found.push_back(r);
    end
    if (typed) begin
      expected_results.push_back(fixed);
    end else begin
      foreach (found[i]) expected_results.push_back(found[i]);
    end
  endfunction

  // Offers one sample, with random idle cycles first, and waits for the transfer.
  task automatic send_sample(input logic [SAMPLE_W-1:0] bits, input logic typed,
                             input result_t fixed);
    @(negedge clk);
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      samples.valid <= 1'b0;
      @(negedge clk);
    end
    samples.valid    <= 1'b1;
    samples.row_bits <= bits;
    do @(posedge clk); while (!samples.ready);
    scan_predict(bits, typed, fixed);
  endtask

  task automatic run_phase(input int count, input int idle, input int stall);
    int                  pick;
    logic [SAMPLE_W-1:0] bits;

    idle_pct  = idle;
    stall_pct = stall;
    repeat (count) begin
      if (pred_col == 0) begin
        pick = $urandom_range(19);
        if (pick < 10) scan_mode = MODE_FLIP;
        else if (pick < 15) scan_mode = MODE_RANDOM;
        else if (pick < 17) scan_mode = MODE_CLEAR;
        else if (pick < 19) scan_mode = MODE_FULL;
        else scan_mode = MODE_HOLD;
      end
      case (scan_mode)
        MODE_FLIP: begin
          // Roughly one key in eight toggles, so scans give a handful of events.
          bits = known_keys[pred_col] ^ SAMPLE_W'($urandom & $urandom & $urandom);
        end
        MODE_RANDOM: bits = SAMPLE_W'($urandom_range(255));
        MODE_CLEAR:  bits = '0;
        MODE_FULL:   bits = '1;
        default:     bits = known_keys[pred_col];
      endcase
      send_sample(bits, 1'b0, '0);
    end
  endtask

  // The receiver either serves a requested hold-off or stalls at random.
  always @(negedge clk) begin
    if (hold_len != 0) begin
      hold_left = hold_len;
      hold_len  = 0;
    end
    if (hold_left != 0) begin
      results.ready <= 1'b0;
      hold_left--;
    end else begin
      results.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && results.valid && results.ready) begin
      if (expected_results.size() == 0) begin
        flag_mismatch("result with nothing expected, event_valid", results.event_valid, 0);
      end else begin
        want_r = expected_results.pop_front();
        if (results.event_valid !== want_r.event_valid)
          flag_mismatch("event_valid", results.event_valid, want_r.event_valid);
        if (results.event_row !== want_r.event_row)
          flag_mismatch("event_row", results.event_row, want_r.event_row);
        if (results.event_col !== want_r.event_col)
          flag_mismatch("event_col", results.event_col, want_r.event_col);
        if (results.key_down !== want_r.key_down)
          flag_mismatch("key_down", results.key_down, want_r.key_down);
        if (results.next_select !== want_r.next_select)
          flag_mismatch("next_select", results.next_select, want_r.next_select);
        if (results.any_pressed !== want_r.any_pressed)
          flag_mismatch("any_pressed", results.any_pressed, want_r.any_pressed);
        if (results.last !== want_r.last)
          flag_mismatch("last", results.last, want_r.last);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("demux_key_matrix_scanner: mismatch");
      $finish;
    end
  end

  initial begin
    result_t fixed;

    rst              = 1'b1;
    samples.valid    = 1'b0;
    samples.row_bits = '0;
    results.ready    = 1'b0;
    idle_pct         = 0;
    stall_pct        = 0;
    hold_len         = 0;
    hold_left        = 0;
    error_count      = 0;
    cycle_count      = 0;
    pred_col         = '0;
    scan_mode        = MODE_FLIP;
    for (int c = 0; c < COLS; c++) begin
      scan_rows[c]  = '0;
      known_keys[c] = '0;
    end

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (probe_table[i]) begin
      fixed = '0;
      fixed.next_select = probe_table[i].sel;
      fixed.any_pressed = probe_table[i].any;
      fixed.last = 1'b1;
      send_sample(probe_table[i].bits, probe_table[i].typed, fixed);
    end

    run_phase(90, 0, 0);
    run_phase(86, 86, 0);
    run_phase(86, 0, 86);
    run_phase(86, 26, 26);
    // Long receiver hold-off while samples keep coming, so the input backs up.
    hold_len = 400;
    run_phase(88, 0, 0);

    @(negedge clk);
    samples.valid <= 1'b0;
    stall_pct = 0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("demux_key_matrix_scanner: match");
    end else begin
      $display("demux_key_matrix_scanner: mismatch");
    end
    $finish;
  end

endmodule

>>> sim.f
sv/kms_pkg.sv
sv/kms_in_if.sv
sv/kms_out_if.sv
sv/kms_ctrl.sv
sv/kms_datapath.sv
sv/demux_key_matrix_scanner.sv
sv/kms_checker.sv
dv/demux_key_matrix_scanner_tb.sv
